/* design/jsu_pkg.sv */
// Package for the JSON string unescape unit.
// Holds the decode mode type, the result group type, character codes and the hex digit helper.
// No dependencies.
package jsu_pkg;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);
  localparam int unsigned HELD_DEPTH  = 3;

  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_U      = 8'h75;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  // Decoded bytes of one input beat
  typedef struct packed {
    logic                              has;
    logic [IDX_W-1:0]                  last_idx;
    logic                              str_last;
    logic [MAX_RESULTS-1:0][7:0]       bytes;
  } group_t;

  // Lenient digit value, low 8 bits
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return c - CHAR_ZERO;
    end
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      v = c + CASE_OFFSET;
    end
    return v - CHAR_LOW_A + 8'd10;
  endfunction

endpackage

/* design/jsu_decoder.sv */
// Escape decoder: mode, hex count and held hex bytes, with the decode of one beat.
// Depends on jsu_pkg.
module jsu_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            string_last,
  output jsu_pkg::group_t res
);
  import jsu_pkg::*;

  mode_t      mode, mode_next;
  logic [1:0] seen, seen_next;
  logic [7:0] held [HELD_DEPTH];
  logic       held_we;
  logic [3:0] hi_digit;

  // only the third held digit reaches the low byte of the code point
  assign hi_digit = 4'(hex_value(held[2]));

  always_comb begin
    res          = '0;
    res.str_last = string_last;
    res.bytes    = {MAX_RESULTS{in_byte}};
    mode_next    = mode;
    seen_next    = seen;
    held_we      = 1'b0;
    case (mode)
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        res.has   = 1'b1;
        case (in_byte)
          CHAR_QUOTE:  res.bytes[0] = CHAR_QUOTE;
          CHAR_BSLASH: res.bytes[0] = CHAR_BSLASH;
          CHAR_SLASH:  res.bytes[0] = CHAR_SLASH;
          CHAR_B:      res.bytes[0] = CTRL_BS;
          CHAR_F:      res.bytes[0] = CTRL_FF;
          CHAR_N:      res.bytes[0] = CTRL_LF;
          CHAR_R:      res.bytes[0] = CTRL_CR;
          CHAR_T:      res.bytes[0] = CTRL_HT;
          CHAR_U: begin
            res.bytes[0] = CHAR_U;
            if (!string_last) begin
              res.has   = 1'b0;
              mode_next = MODE_HEX;
              seen_next = 2'd0;
            end
          end
          default: begin
            res.bytes[0] = CHAR_BSLASH;
            res.bytes[1] = in_byte;
            res.last_idx = IDX_W'(1);
          end
        endcase
      end
      MODE_HEX: begin
        if (seen == 2'd3) begin
          res.has      = 1'b1;
          res.bytes[0] = {hi_digit, 4'b0000} + hex_value(in_byte);
          mode_next    = MODE_NORMAL;
          seen_next    = 2'd0;
        end else if (string_last) begin
          // cut short: 'u', held bytes, current byte
          res.has      = 1'b1;
          res.bytes[0] = CHAR_U;
          res.bytes[1] = (seen >= 2'd1) ? held[0] : in_byte;
          res.bytes[2] = (seen >= 2'd2) ? held[1] : in_byte;
          res.bytes[3] = in_byte;
          res.last_idx = IDX_W'(seen + 2'd1);
        end else begin
          held_we   = 1'b1;
          seen_next = seen + 2'd1;
        end
      end
      default: begin
        if (in_byte == CHAR_BSLASH && !string_last) begin
          mode_next = MODE_ESCAPE;
        end else begin
          res.has = 1'b1;
        end
      end
    endcase
    if (string_last) begin
      mode_next = MODE_NORMAL;
      seen_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      seen <= 2'd0;
    end else if (accept) begin
      mode <= mode_next;
      seen <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[seen] <= in_byte;
    end
  end

endmodule

/* design/jsu_serializer.sv */
// Result register: holds one beat's decoded bytes and sends them out one per cycle while m_tready is high.
// Depends on jsu_pkg.
module jsu_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jsu_pkg::group_t res,
  output logic            can_load,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tuser,   // run_last
  output logic            m_tlast    // out_string_last
);
  import jsu_pkg::*;

  group_t           grp;
  logic             valid;
  logic [IDX_W-1:0] idx;
  logic             take, done;

  assign take     = valid && m_tready;
  assign done     = take && (idx == grp.last_idx);
  assign can_load = !valid || done;

  assign m_tvalid = valid;
  assign m_tdata  = grp.bytes[idx];
  assign m_tuser  = (idx == grp.last_idx);
  assign m_tlast  = m_tuser && grp.str_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (done) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= res;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= grp.last_idx)
    else $error("result index past last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(load && valid && !done))
    else $error("result group overwritten before drained");

  a_tlast_on_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("string end off a run end");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    done && !load |=> !m_tvalid)
    else $error("valid held after final byte");

endmodule

/* design/json_string_unescape_unit.sv */
// JSON string unescape unit: one raw byte per beat in, decoded bytes out.
// A decoded beat's first byte is on m_tdata in the cycle after it is accepted.
// Throughput: one input beat per cycle when m_tready is high; a beat that yields k bytes
// holds s_tready low until the cycle its last byte is taken, sending them one per cycle.
// Reset (rst, synchronous): normal mode, no hex digits held, output empty.
// Depends on jsu_pkg, jsu_decoder, jsu_serializer.
module json_string_unescape_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // string_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tuser,   // run_last
  output logic       m_tlast    // out_string_last
);
  import jsu_pkg::*;

  group_t res;
  logic   accept;
  logic   can_load;

  assign s_tready = can_load;
  assign accept   = s_tvalid && s_tready;

  jsu_decoder u_dec (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (s_tdata),
    .string_last (s_tlast),
    .res         (res)
  );

  jsu_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res.has),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
